### src/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define KCMT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define KCMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/kcmt_pkg.sv
// shared types, sizes and codes of the key combination match table
package kcmt_pkg;

  localparam int MAX_ENTRIES     = 32;
  localparam int ACTION_ID_WIDTH = 16;
  localparam int IDX_W           = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W           = $clog2(MAX_ENTRIES + 1);

  typedef logic [ACTION_ID_WIDTH-1:0] action_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [MAX_ENTRIES-1:0]     lane_vec_t;

  localparam logic [2:0] MODE_INSERT     = 3'd0;
  localparam logic [2:0] MODE_INSERT_ARG = 3'd1;
  localparam logic [2:0] MODE_REMOVE     = 3'd2;
  localparam logic [2:0] MODE_LOOKUP     = 3'd3;
  localparam logic [2:0] MODE_CLEAR      = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [15:0] IGNORE_MASK_RESET = 16'd18;

  typedef struct packed {
    logic [15:0] mods;
    logic [7:0]  key;
    action_t     action;
    logic [31:0] arg;
    logic        mark;
  } entry_t;

  typedef struct packed {
    logic [15:0] mods;
    logic [7:0]  key;
    logic [15:0] keep;
  } probe_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

### src/key_combination_match_table.sv
// top level of the key combination match table: control, result register and the cell row
//
//   channel  ports                                   handshake
//   input    in_mode .. in_argument                  start && !busy
//   result   out_status .. out_entry_count           out_valid, one cycle, no stall
//   config   cfg_data                                cfg_valid && cfg_ready
//
// an operation runs through these steps in order: compare in all cells, first-hit encode, the update
// of the cell row together with the result register, then the result strobe
// busy is high in S_CMP, S_ENC and S_EXEC after the accept; the result strobes back in S_IDLE,
// and the next beat can be taken at the edge that ends the strobe cycle
// rst_n is synchronous, active low; the table is empty and usable right after it
// the result side cannot stall; cfg_ready is always high
module key_combination_match_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [15:0] in_modifiers,
  input  logic [7:0]  in_key_code,
  input  logic [15:0] in_action_id,
  input  logic [31:0] in_argument,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [4:0]  out_entry_index,
  output logic [15:0] out_found_action,
  output logic [31:0] out_found_argument,
  output logic        out_found_has_argument,
  output logic [15:0] out_found_modifiers,
  output logic [5:0]  out_entry_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_ENC, S_EXEC} state_t;

  state_t                    state_r;
  logic [15:0]               ignore_r;
  kcmt_pkg::cnt_t            cnt_r;
  logic [2:0]                mode_r;
  logic [15:0]               mods_r;
  logic [7:0]                key_r;
  kcmt_pkg::action_t         action_r;
  logic [31:0]               arg_r;
  kcmt_pkg::lane_vec_t       hit_r;
  kcmt_pkg::lane_vec_t       sel_r;
  kcmt_pkg::idx_t            sel_idx_r;
  logic                      sel_any_r;

  kcmt_pkg::entry_t          cell_q   [kcmt_pkg::MAX_ENTRIES];
  kcmt_pkg::entry_t          cell_nxt [kcmt_pkg::MAX_ENTRIES];
  kcmt_pkg::cell_ctl_t       cell_ctl [kcmt_pkg::MAX_ENTRIES];
  kcmt_pkg::lane_vec_t       hit;
  kcmt_pkg::lane_vec_t       live;
  kcmt_pkg::lane_vec_t       first;
  kcmt_pkg::idx_t            first_idx;
  kcmt_pkg::probe_t          probe;
  kcmt_pkg::entry_t          new_entry;
  kcmt_pkg::entry_t          rd;
  logic                      is_insert;
  logic                      insert_ok;
  logic                      remove_ok;

  logic [2:0]                status_nxt;
  logic [4:0]                index_nxt;
  kcmt_pkg::cnt_t            cnt_nxt;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign probe.mods = mods_r;
  assign probe.key  = key_r;
  assign probe.keep = ~ignore_r;

  assign new_entry.mods   = mods_r;
  assign new_entry.key    = key_r;
  assign new_entry.action = action_r;
  assign new_entry.arg    = (mode_r == kcmt_pkg::MODE_INSERT_ARG) ? arg_r : 32'd0;
  assign new_entry.mark   = (mode_r == kcmt_pkg::MODE_INSERT_ARG);

  assign is_insert = (mode_r == kcmt_pkg::MODE_INSERT) ||
                     (mode_r == kcmt_pkg::MODE_INSERT_ARG);
  assign insert_ok = is_insert && (action_r != '0) && !sel_any_r &&
                     (cnt_r < kcmt_pkg::cnt_t'(kcmt_pkg::MAX_ENTRIES));
  assign remove_ok = (mode_r == kcmt_pkg::MODE_REMOVE) && sel_any_r;

  assign first = hit_r & (~hit_r + kcmt_pkg::lane_vec_t'(1));

  always_comb begin
    live      = '0;
    first_idx = '0;
    rd        = '0;
    for (int i = 0; i < kcmt_pkg::MAX_ENTRIES; i++) begin
      live[i] = (kcmt_pkg::cnt_t'(i) < cnt_r);
      if (first[i]) begin
        first_idx = first_idx | kcmt_pkg::idx_t'(i);
      end
      if (sel_r[i]) begin
        rd = rd | cell_q[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < kcmt_pkg::MAX_ENTRIES; i++) begin
      cell_ctl[i].load  = (state_r == S_EXEC) && insert_ok &&
                          (kcmt_pkg::cnt_t'(i) == cnt_r);
      cell_ctl[i].shift = (state_r == S_EXEC) && remove_ok &&
                          (kcmt_pkg::idx_t'(i) >= sel_idx_r);
    end
  end

  for (genvar g = 0; g < kcmt_pkg::MAX_ENTRIES; g++) begin : g_cell
    if (g == kcmt_pkg::MAX_ENTRIES - 1) begin : g_last
      assign cell_nxt[g] = cell_q[g];
    end else begin : g_mid
      assign cell_nxt[g] = cell_q[g+1];
    end
    kcmt_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[g]),
      .load_data (new_entry),
      .next_data (cell_nxt[g]),
      .probe     (probe),
      .entry_q   (cell_q[g]),
      .hit       (hit[g])
    );
  end

  always_comb begin
    status_nxt = kcmt_pkg::ST_OK;
    index_nxt  = 5'd0;
    cnt_nxt    = cnt_r;
    case (mode_r)
      kcmt_pkg::MODE_INSERT, kcmt_pkg::MODE_INSERT_ARG: begin
        if (action_r == '0) begin
          status_nxt = kcmt_pkg::ST_EMPTY;
        end else if (sel_any_r) begin
          status_nxt = kcmt_pkg::ST_DUP;
          index_nxt  = 5'(sel_idx_r);
        end else if (!insert_ok) begin
          status_nxt = kcmt_pkg::ST_FULL;
        end else begin
          index_nxt = 5'(cnt_r);
          cnt_nxt   = cnt_r + kcmt_pkg::cnt_t'(1);
        end
      end
      kcmt_pkg::MODE_REMOVE: begin
        if (sel_any_r) begin
          index_nxt = 5'(sel_idx_r);
          cnt_nxt   = cnt_r - kcmt_pkg::cnt_t'(1);
        end else begin
          status_nxt = kcmt_pkg::ST_NOTFOUND;
        end
      end
      kcmt_pkg::MODE_LOOKUP: begin
        if (sel_any_r) begin
          index_nxt = 5'(sel_idx_r);
        end else begin
          status_nxt = kcmt_pkg::ST_NOTFOUND;
        end
      end
      kcmt_pkg::MODE_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ignore_r  <= kcmt_pkg::IGNORE_MASK_RESET;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        ignore_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            mode_r   <= in_mode;
            mods_r   <= in_modifiers;
            key_r    <= in_key_code;
            action_r <= kcmt_pkg::action_t'(in_action_id);
            arg_r    <= in_argument;
            state_r  <= S_CMP;
          end
        end
        S_CMP: begin
          hit_r   <= hit & live;
          state_r <= S_ENC;
        end
        S_ENC: begin
          sel_r     <= first;
          sel_idx_r <= first_idx;
          sel_any_r <= |hit_r;
          state_r   <= S_EXEC;
        end
        S_EXEC: begin
          cnt_r                  <= cnt_nxt;
          out_valid              <= 1'b1;
          out_status             <= status_nxt;
          out_entry_index        <= index_nxt;
          out_entry_count        <= 6'(cnt_nxt);
          if ((mode_r == kcmt_pkg::MODE_LOOKUP) && sel_any_r) begin
            out_found_action       <= 16'(rd.action);
            out_found_argument     <= rd.arg;
            out_found_has_argument <= rd.mark;
            out_found_modifiers    <= rd.mods;
          end else begin
            out_found_action       <= 16'd0;
            out_found_argument     <= 32'd0;
            out_found_has_argument <= 1'b0;
            out_found_modifiers    <= 16'd0;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/kcmt_cell.sv
// one table slot: holds a binding loaded on an insert, compares it, takes its upper neighbor on a remove
module kcmt_cell (
  input  logic                clk,
  input  kcmt_pkg::cell_ctl_t ctl,
  input  kcmt_pkg::entry_t    load_data,
  input  kcmt_pkg::entry_t    next_data,
  input  kcmt_pkg::probe_t    probe,
  output kcmt_pkg::entry_t    entry_q,
  output logic                hit
);

  kcmt_pkg::entry_t entry_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry_r <= load_data;
    end else if (ctl.shift) begin
      entry_r <= next_data;
    end
  end

  assign entry_q = entry_r;
  assign hit     = (entry_r.key == probe.key) &&
                   (((entry_r.mods ^ probe.mods) & probe.keep) == 16'd0);

endmodule

### src/kcmt_checker.sv
// port-level checks of the key combination match table and their bind
`include "assert_macros.svh"

module kcmt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [15:0] out_found_action,
  input logic        out_found_has_argument
);

  `KCMT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `KCMT_ASSERT_NEXT(a_result_latency, start && !busy, ##3 out_valid, "late or missing result")
  `KCMT_ASSERT_IMP(a_result_idle, out_valid, !busy, "result strobe while busy")
  `KCMT_ASSERT_IMP(a_miss_no_data, out_valid && (out_status != kcmt_pkg::ST_OK),
    (out_found_action == 16'd0) && !out_found_has_argument, "found fields set on a failed beat")

endmodule

bind key_combination_match_table kcmt_checker u_kcmt_checker (.*);
